// ===== rtl/mqcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT client receiver package
// Shared codes, defaults and the structures passed between the parser, the
// payload buffer and the top level.
// ----------------------------------------------------------------------------
package mqcr_pkg;

    // Default payload buffer size in bytes.
    localparam int BUF_BYTES_DEF = 256;

    // Input word kinds (carried on s_tuser).
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Session states.
    localparam logic [1:0] SES_CLOSED     = 2'd0;
    localparam logic [1:0] SES_CONNECTING = 2'd1;
    localparam logic [1:0] SES_OPEN       = 2'd2;
    localparam logic [1:0] SES_CLOSING    = 2'd3;

    // Parser phases.
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN1 = 2'd1;
    localparam logic [1:0] PH_LEN2 = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // Result event codes (carried on m_tuser).
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_CONNACK  = 3'd1;
    localparam logic [2:0] EV_PUBLISH  = 3'd2;
    localparam logic [2:0] EV_ANSWERED = 3'd3;
    localparam logic [2:0] EV_ACK      = 3'd4;
    localparam logic [2:0] EV_DUP      = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;
    localparam logic [2:0] EV_READ     = 3'd7;

    // Packet type nibbles as they appear in the fixed header.
    localparam logic [3:0] PT_CONNACK  = 4'h2;
    localparam logic [3:0] PT_PUBLISH  = 4'h3;
    localparam logic [3:0] PT_PUBACK   = 4'h4;
    localparam logic [3:0] PT_PUBREC   = 4'h5;
    localparam logic [3:0] PT_PUBREL   = 4'h6;
    localparam logic [3:0] PT_PUBCOMP  = 4'h7;
    localparam logic [3:0] PT_SUBACK   = 4'h9;
    localparam logic [3:0] PT_UNSUBACK = 4'hB;
    localparam logic [3:0] PT_PINGRESP = 4'hD;

    // First bytes of the four-byte replies.
    localparam logic [7:0] RPL_PUBACK  = 8'h40;
    localparam logic [7:0] RPL_PUBREC  = 8'h50;
    localparam logic [7:0] RPL_PUBREL  = 8'h60;
    localparam logic [7:0] RPL_PUBCOMP = 8'h70;

    // One result word before the read data is merged in.
    typedef struct packed {
        logic [2:0]  event_res;
        logic        reply_valid;
        logic [7:0]  reply_type;
        logic [15:0] reply_id;
        logic [1:0]  pub_qos;
        logic        pub_retain;
        logic [7:0]  topic_length;
        logic [7:0]  msg_start;
        logic [7:0]  msg_length;
        logic        rd_hit;
        logic [1:0]  session;
    } result_t;

    // Payload buffer access for one accepted word.
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } mem_cmd_t;

endpackage

// ===== rtl/mqtt_client_packet_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT client packet receiver
// Parses the server-to-client byte stream of an MQTT 3.1.1 session and
// reports one result word for every input word.
// ----------------------------------------------------------------------------
// Result: every input word gives its result word in the cycle after it is
// accepted; read-buffer words take their data from the buffer RAM's
// registered read port in that same cycle.
// Throughput: one word per cycle while m_tready drains the single output register.
// Reset: aresetn (synchronous, active low) closes the session and restarts
// the parser; the payload buffer is not cleared and holds garbage until written.
module mqtt_client_packet_receiver #(
    parameter int BUF_BYTES = mqcr_pkg::BUF_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] rx_byte, [15:8] read_addr
    input  logic [1:0]  s_tuser,  // [1:0] mode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // [0] reply_valid, [8:1] reply_type,
                                  // [24:9] reply_id, [26:25] pub_qos,
                                  // [27] pub_retain, [35:28] topic_length,
                                  // [43:36] msg_start, [51:44] msg_length,
                                  // [59:52] read_data, [61:60] session,
                                  // [63:62] zero
    output logic [2:0]  m_tuser   // [2:0] event_res
);

    localparam int AW = $clog2(BUF_BYTES);

    logic               in_accept;
    mqcr_pkg::result_t  res;
    mqcr_pkg::mem_cmd_t mem_cmd;
    mqcr_pkg::result_t  res_reg;
    logic               m_valid_reg;
    logic [7:0]         rd_data;
    logic [7:0]         read_data;

    // The output register advances whenever it is empty or being drained,
    // so a word can enter every cycle while results keep flowing.
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // All framing and decode state; evaluates the accepted word and
    // produces its result together with the buffer access it needs.
    mqcr_parser #(
        .BUF_BYTES (BUF_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .mode      (s_tuser),
        .rx_byte   (s_tdata[7:0]),
        .read_addr (s_tdata[15:8]),
        .res       (res),
        .mem_cmd   (mem_cmd)
    );

    // Payload buffer. Writes land at the accepting edge; a read issued by a
    // later word therefore always sees them, and the read data register
    // only loads when a read word is accepted so it holds through stalls.
    mqcr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr[AW-1:0]),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_reg <= res;
        end
    end

    // Addresses beyond the buffer read as zero.
    assign read_data = (res_reg.event_res == mqcr_pkg::EV_READ && res_reg.rd_hit)
                       ? rd_data : 8'd0;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {2'b00,
                       res_reg.session,
                       read_data,
                       res_reg.msg_length,
                       res_reg.msg_start,
                       res_reg.topic_length,
                       res_reg.pub_retain,
                       res_reg.pub_qos,
                       res_reg.reply_id,
                       res_reg.reply_type,
                       res_reg.reply_valid};

endmodule

// ===== rtl/mqcr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mqcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mqcr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT client receiver parser
// Session and packet framing state, payload buffer addressing and the
// end-of-packet decode, one input word per cycle while in_accept is high.
// ----------------------------------------------------------------------------
module mqcr_parser #(
    parameter int BUF_BYTES = mqcr_pkg::BUF_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [1:0]         mode,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         read_addr,
    output mqcr_pkg::result_t  res,
    output mqcr_pkg::mem_cmd_t mem_cmd
);

    localparam logic [14:0] LEN_LIMIT = 15'(BUF_BYTES);
    localparam logic [8:0]  RD_LIMIT  = 9'(BUF_BYTES);

    logic [1:0]  ses_reg,   ses_next;
    logic [1:0]  ph_reg,    ph_next;
    logic [7:0]  type_reg,  type_next;
    logic [7:0]  len_reg,   len_next;
    logic [7:0]  fill_reg,  fill_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] id_reg,    id_next;

    function automatic logic type_ok(input logic [3:0] nib);
        logic ok;
        ok = (nib == mqcr_pkg::PT_CONNACK)  || (nib == mqcr_pkg::PT_PUBLISH)  ||
             (nib == mqcr_pkg::PT_PUBACK)   || (nib == mqcr_pkg::PT_PUBREC)   ||
             (nib == mqcr_pkg::PT_PUBREL)   || (nib == mqcr_pkg::PT_PUBCOMP)  ||
             (nib == mqcr_pkg::PT_SUBACK)   || (nib == mqcr_pkg::PT_UNSUBACK) ||
             (nib == mqcr_pkg::PT_PINGRESP);
        return ok;
    endfunction

    always_comb begin
        logic        fail;
        logic        got;
        logic        fin;
        logic [14:0] glen;
        logic [8:0]  fill_inc;
        logic [16:0] id_hi_pos;
        logic [16:0] id_lo_pos;
        logic [16:0] fill_ext;
        logic [1:0]  qos;
        logic [7:0]  rem;
        logic [7:0]  start;

        ses_next   = ses_reg;
        ph_next    = ph_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        first_next = first_reg;
        id_next    = id_reg;
        res        = '0;
        mem_cmd    = '0;
        fail       = 1'b0;
        got        = 1'b0;
        fin        = 1'b0;
        glen       = '0;
        fill_inc   = {1'b0, fill_reg} + 9'd1;
        fill_ext   = {9'd0, fill_reg};
        id_hi_pos  = {1'b0, first_reg} + 17'd2;
        id_lo_pos  = {1'b0, first_reg} + 17'd3;
        qos        = type_reg[2:1];
        rem        = '0;
        start      = '0;

        if (in_accept) begin
            unique case (mode)
                mqcr_pkg::MODE_BYTE: begin
                    if (ses_reg == mqcr_pkg::SES_CONNECTING ||
                        ses_reg == mqcr_pkg::SES_OPEN) begin
                        unique case (ph_reg)
                            mqcr_pkg::PH_TYPE: begin
                                if (type_ok(rx_byte[7:4])) begin
                                    type_next = rx_byte;
                                    ph_next   = mqcr_pkg::PH_LEN1;
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                            mqcr_pkg::PH_LEN1: begin
                                if (rx_byte[7]) begin
                                    len_next = {1'b0, rx_byte[6:0]};
                                    ph_next  = mqcr_pkg::PH_LEN2;
                                end else begin
                                    got  = 1'b1;
                                    glen = {8'd0, rx_byte[6:0]};
                                end
                            end
                            mqcr_pkg::PH_LEN2: begin
                                got  = 1'b1;
                                glen = {rx_byte, len_reg[6:0]};
                            end
                            mqcr_pkg::PH_DATA: begin
                                mem_cmd.we    = 1'b1;
                                mem_cmd.waddr = fill_reg;
                                mem_cmd.wdata = rx_byte;
                                if (fill_reg == 8'd0) begin
                                    first_next = {rx_byte, 8'd0};
                                end else if (fill_reg == 8'd1) begin
                                    first_next = {first_reg[15:8], rx_byte};
                                end
                                // The packet identifier sits right after the topic;
                                // catch it as it streams past.
                                if (fill_ext == id_hi_pos) begin
                                    id_next[15:8] = rx_byte;
                                end
                                if (fill_ext == id_lo_pos) begin
                                    id_next[7:0] = rx_byte;
                                end
                                fill_next = fill_inc[7:0];
                                if (fill_inc >= {1'b0, len_reg}) begin
                                    fin = 1'b1;
                                end
                            end
                            default: ph_next = mqcr_pkg::PH_TYPE;
                        endcase
                    end
                end
                mqcr_pkg::MODE_OPEN: begin
                    ses_next = mqcr_pkg::SES_CONNECTING;
                    ph_next  = mqcr_pkg::PH_TYPE;
                end
                mqcr_pkg::MODE_CLOSE: begin
                    ses_next = mqcr_pkg::SES_CLOSED;
                    ph_next  = mqcr_pkg::PH_TYPE;
                end
                mqcr_pkg::MODE_READ: begin
                    res.event_res = mqcr_pkg::EV_READ;
                    res.rd_hit    = ({1'b0, read_addr} < RD_LIMIT);
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = read_addr;
                end
                default: ;
            endcase
        end

        // Remaining length complete.
        if (got) begin
            if (glen >= 15'd256 || glen > LEN_LIMIT) begin
                fail = 1'b1;
            end else begin
                len_next   = glen[7:0];
                fill_next  = 8'd0;
                first_next = 16'd0;
                id_next    = 16'd0;
                if (glen == 15'd0) begin
                    fin = 1'b1;
                end else begin
                    ph_next = mqcr_pkg::PH_DATA;
                end
            end
        end

        // Whole packet received: decode it.
        if (fin) begin
            ph_next = mqcr_pkg::PH_TYPE;
            unique case (type_reg[7:4])
                mqcr_pkg::PT_CONNACK: begin
                    if (ses_reg == mqcr_pkg::SES_CONNECTING && len_next == 8'd2 &&
                        first_next[7:0] == 8'd0) begin
                        ses_next      = mqcr_pkg::SES_OPEN;
                        res.event_res = mqcr_pkg::EV_CONNACK;
                    end else begin
                        fail = 1'b1;
                    end
                end
                mqcr_pkg::PT_PUBLISH: begin
                    if (ses_reg != mqcr_pkg::SES_OPEN || len_next < 8'd4) begin
                        fail = 1'b1;
                    end else if (type_reg[3]) begin
                        res.event_res = mqcr_pkg::EV_DUP;
                    end else if (first_next > {8'd0, len_next - 8'd2}) begin
                        fail = 1'b1;
                    end else begin
                        rem   = len_next - 8'd2 - first_next[7:0];
                        start = 8'd2 + first_next[7:0];
                        if (qos != 2'd0 && rem < 8'd2) begin
                            fail = 1'b1;
                        end else begin
                            if (qos != 2'd0) begin
                                rem             = rem - 8'd2;
                                start           = start + 8'd2;
                                res.reply_valid = 1'b1;
                                res.reply_type  = (qos == 2'd1) ? mqcr_pkg::RPL_PUBACK
                                                                : mqcr_pkg::RPL_PUBREC;
                                res.reply_id    = id_next;
                            end
                            res.event_res    = mqcr_pkg::EV_PUBLISH;
                            res.pub_qos      = qos;
                            res.pub_retain   = type_reg[0];
                            res.topic_length = first_next[7:0];
                            res.msg_start    = start;
                            res.msg_length   = rem;
                        end
                    end
                end
                mqcr_pkg::PT_PUBREC, mqcr_pkg::PT_PUBREL: begin
                    if (len_next == 8'd2) begin
                        res.event_res   = mqcr_pkg::EV_ANSWERED;
                        res.reply_valid = 1'b1;
                        res.reply_type  = (type_reg[7:4] == mqcr_pkg::PT_PUBREC)
                                          ? mqcr_pkg::RPL_PUBREL : mqcr_pkg::RPL_PUBCOMP;
                        res.reply_id    = first_next;
                    end else begin
                        fail = 1'b1;
                    end
                end
                mqcr_pkg::PT_PUBACK, mqcr_pkg::PT_PUBCOMP, mqcr_pkg::PT_SUBACK,
                mqcr_pkg::PT_UNSUBACK, mqcr_pkg::PT_PINGRESP: begin
                    res.event_res = mqcr_pkg::EV_ACK;
                end
                default: fail = 1'b1;
            endcase
        end

        if (fail) begin
            res           = '0;
            res.event_res = mqcr_pkg::EV_ERROR;
            ses_next      = mqcr_pkg::SES_CLOSING;
            ph_next       = mqcr_pkg::PH_TYPE;
        end

        res.session = ses_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ses_reg   <= mqcr_pkg::SES_CLOSED;
            ph_reg    <= mqcr_pkg::PH_TYPE;
            type_reg  <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            first_reg <= '0;
            id_reg    <= '0;
        end else begin
            ses_reg   <= ses_next;
            ph_reg    <= ph_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            first_reg <= first_next;
            id_reg    <= id_next;
        end
    end

endmodule

// ===== rtl/mqcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT client receiver checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mqcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // With nothing pending the block must take input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // Replies only come from a publish or a pubrec/pubrel answer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            (m_tuser == mqcr_pkg::EV_PUBLISH || m_tuser == mqcr_pkg::EV_ANSWERED))
        else $error("reply flagged on a non-reply event");

    // A protocol error always leaves the session closing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mqcr_pkg::EV_ERROR |->
            m_tdata[61:60] == mqcr_pkg::SES_CLOSING)
        else $error("error event without closing session");

    // An open event shows up next cycle as a plain connecting result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == mqcr_pkg::MODE_OPEN |=>
            m_tvalid && m_tuser == mqcr_pkg::EV_NONE &&
            m_tdata[61:60] == mqcr_pkg::SES_CONNECTING)
        else $error("open event not reported as connecting");

endmodule

bind mqtt_client_packet_receiver mqcr_checker u_mqcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/mqtt_client_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT client packet receiver testbench
// Drives connect/close events, stream bytes and buffer reads into the
// receiver and checks every result word against a cycle-free model of the
// session, the packet parser and the payload buffer kept inside the bench.
// ----------------------------------------------------------------------------
module mqtt_client_packet_receiver_tb;

    import mqcr_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles without any handshake
    localparam int DRAIN_WAIT  = 8;     // cycles after the last result
    localparam int WORD_TARGET = 1650;

    // One input word as the bench sees it.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx;
        logic [7:0] addr;
    } in_word_t;

    // One result word, field by field.
    typedef struct packed {
        logic [2:0]  ev;
        logic        reply_valid;
        logic [7:0]  reply_type;
        logic [15:0] reply_id;
        logic [1:0]  qos;
        logic        retain;
        logic [7:0]  topic_cnt;
        logic [7:0]  msg_start;
        logic [7:0]  msg_len;
        logic [7:0]  read_data;
        logic [1:0]  session;
        logic [1:0]  pad;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = MODE_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    // Words waiting to be driven and the results they must produce, in order.
    in_word_t tx_words[$];
    outcome_t pending_results[$];
    logic [7:0] body_q[$];

    int words_sent   = 0;
    int total_words  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    // Bench copy of the receiver state.
    logic [1:0]  sess;
    logic [1:0]  phase;
    logic [7:0]  pkt_hdr;
    logic [7:0]  pkt_len;
    logic [7:0]  fill_pos;
    logic [15:0] lead_id;
    logic [7:0]  pay_mem [256];
    bit          pay_written [256];
    outcome_t    verdict;

    always #5 aclk = ~aclk;

    mqtt_client_packet_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Receiver model
    // ------------------------------------------------------------------

    // A protocol error drops the session to closing and restarts parsing.
    task automatic raise_error();
        verdict.ev = EV_ERROR;
        sess       = SES_CLOSING;
        phase      = PH_TYPE;
    endtask

    task automatic set_reply(input logic [7:0] kind, input logic [15:0] id);
        verdict.reply_valid = 1'b1;
        verdict.reply_type  = kind;
        verdict.reply_id    = id;
    endtask

    // Decide the outcome of a packet whose last byte has just arrived.
    task automatic close_packet();
        int unsigned len, tl, rem, start;
        logic [15:0] id;
        logic [1:0]  qos;
        len   = pkt_len;
        qos   = pkt_hdr[2:1];
        phase = PH_TYPE;
        case (pkt_hdr[7:4])
            PT_CONNACK: begin
                if (sess == SES_CONNECTING && len == 2 && pay_mem[1] == 8'h00) begin
                    sess       = SES_OPEN;
                    verdict.ev = EV_CONNACK;
                end else begin
                    raise_error();
                end
            end
            PT_PUBLISH: begin
                if (sess != SES_OPEN || len < 4) begin
                    raise_error();
                end else if (pkt_hdr[3]) begin
                    // A duplicate delivery is dropped without looking inside.
                    verdict.ev = EV_DUP;
                end else begin
                    tl  = {pay_mem[0], pay_mem[1]};
                    rem = len - 2;
                    id  = '0;
                    if (tl > rem) begin
                        raise_error();
                    end else begin
                        rem   = rem - tl;
                        start = 2 + tl;
                        if (qos != 2'd0 && rem < 2) begin
                            raise_error();
                        end else begin
                            if (qos != 2'd0) begin
                                id    = {pay_mem[start[7:0]], pay_mem[start[7:0] + 8'd1]};
                                start = start + 2;
                                rem   = rem - 2;
                                set_reply(qos == 2'd1 ? RPL_PUBACK : RPL_PUBREC, id);
                            end
                            verdict.ev        = EV_PUBLISH;
                            verdict.qos       = qos;
                            verdict.retain    = pkt_hdr[0];
                            verdict.topic_cnt = tl[7:0];
                            verdict.msg_start = start[7:0];
                            verdict.msg_len   = rem[7:0];
                        end
                    end
                end
            end
            PT_PUBREC, PT_PUBREL: begin
                if (len == 2) begin
                    verdict.ev = EV_ANSWERED;
                    set_reply(pkt_hdr[7:4] == PT_PUBREC ? RPL_PUBREL : RPL_PUBCOMP,
                              lead_id);
                end else begin
                    raise_error();
                end
            end
            PT_PUBACK, PT_PUBCOMP, PT_SUBACK, PT_UNSUBACK, PT_PINGRESP: begin
                verdict.ev = EV_ACK;
            end
            default: begin
                raise_error();
            end
        endcase
    endtask

    task automatic take_length(input int unsigned len);
        if (len >= 256) begin
            raise_error();
        end else begin
            pkt_len  = len[7:0];
            fill_pos = '0;
            lead_id  = '0;
            if (len == 0) begin
                close_packet();
            end else begin
                phase = PH_DATA;
            end
        end
    endtask

    function automatic bit known_type(input logic [3:0] nib);
        case (nib)
            PT_CONNACK, PT_PUBLISH, PT_PUBACK, PT_PUBREC, PT_PUBREL,
            PT_PUBCOMP, PT_SUBACK, PT_UNSUBACK, PT_PINGRESP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic take_byte(input logic [7:0] b);
        case (phase)
            PH_TYPE: begin
                if (!known_type(b[7:4])) begin
                    raise_error();
                end else begin
                    pkt_hdr = b;
                    phase   = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (b[7]) begin
                    pkt_len = {1'b0, b[6:0]};
                    phase   = PH_LEN2;
                end else begin
                    take_length(b);
                end
            end
            PH_LEN2: begin
                take_length(int'(pkt_len) | (int'(b) << 7));
            end
            default: begin
                pay_mem[fill_pos]     = b;
                pay_written[fill_pos] = 1'b1;
                if (fill_pos == 8'd0) begin
                    lead_id = {b, 8'h00};
                end else if (fill_pos == 8'd1) begin
                    lead_id[7:0] = b;
                end
                fill_pos = fill_pos + 8'd1;
                if (fill_pos >= pkt_len) begin
                    close_packet();
                end
            end
        endcase
    endtask

    // Advance the model by one input word and return the result it gives.
    task automatic receive_word(input in_word_t w, output outcome_t o);
        verdict = '0;
        case (w.mode)
            MODE_BYTE: begin
                if (sess == SES_CONNECTING || sess == SES_OPEN) begin
                    take_byte(w.rx);
                end
            end
            MODE_OPEN: begin
                sess  = SES_CONNECTING;
                phase = PH_TYPE;
            end
            MODE_CLOSE: begin
                sess  = SES_CLOSED;
                phase = PH_TYPE;
            end
            default: begin
                verdict.ev        = EV_READ;
                verdict.read_data = pay_mem[w.addr];
            end
        endcase
        verdict.session = sess;
        o = verdict;
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic push_word(input logic [1:0] mode, input logic [7:0] rx,
                             input logic [7:0] addr);
        in_word_t w;
        outcome_t o;
        w.mode = mode;
        w.rx   = rx;
        w.addr = addr;
        receive_word(w, o);
        tx_words.push_back(w);
        pending_results.push_back(o);
    endtask

    // Unused fields of a word carry random values so every bit toggles.
    task automatic push_byte(input logic [7:0] b);
        push_word(MODE_BYTE, b, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_event(input logic [1:0] mode);
        push_word(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Reads only touch buffer bytes that some packet has already stored.
    task automatic push_read(input logic [7:0] addr);
        int k;
        for (k = 0; k < 256 && !pay_written[(int'(addr) + k) % 256]; k++) ;
        if (k < 256) begin
            push_word(MODE_READ, 8'($urandom_range(0, 255)), 8'((int'(addr) + k) % 256));
        end
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Sends header, remaining length and the body collected in body_q.
    task automatic emit_packet(input logic [7:0] hdr, input bit two_byte_len);
        int len;
        len = body_q.size();
        push_byte(hdr);
        if (two_byte_len || len >= 128) begin
            push_byte({1'b1, 7'(len)});
            push_byte(8'(len >> 7));
        end else begin
            push_byte(8'(len));
        end
        foreach (body_q[i]) push_byte(body_q[i]);
        body_q.delete();
    endtask

    task automatic send_connack(input bit good);
        body_q.delete();
        if (good || $urandom_range(0, 1)) begin
            body_q.push_back(8'($urandom_range(0, 255)));
            body_q.push_back(good || $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        end else begin
            add_random_bytes($urandom_range(0, 3));
        end
        emit_packet({PT_CONNACK, 4'($urandom_range(0, 15))}, $urandom_range(0, 3) == 0);
    endtask

    // A publish, mostly well formed; a few have a topic that overruns the
    // packet, a missing packet identifier or a body too short to hold a topic.
    task automatic send_publish(input bit big);
        int tl, ml, flaw, tl_claim, idl;
        logic [1:0] qos;
        bit dup;
        qos  = 2'($urandom_range(0, 3));
        dup  = ($urandom_range(0, 7) == 0);
        flaw = big ? 9 : $urandom_range(0, 9);
        idl  = (qos != 2'd0) ? 2 : 0;
        if (big) begin
            tl = $urandom_range(0, 200);
            ml = 253 - tl - idl;
        end else begin
            tl = $urandom_range(0, 6);
            ml = $urandom_range(0, 8);
        end
        if (flaw == 1 && qos != 2'd0) begin
            idl = 0;
            ml  = $urandom_range(0, 1);
        end
        tl_claim = (flaw == 0) ? tl + idl + ml + $urandom_range(1, 3) : tl;
        if (flaw == 0 && $urandom_range(0, 3) == 0) begin
            tl_claim = $urandom_range(256, 65535);
        end
        body_q.delete();
        if (flaw == 2) begin
            add_random_bytes($urandom_range(0, 3));
        end else begin
            body_q.push_back(8'(tl_claim >> 8));
            body_q.push_back(8'(tl_claim));
            add_random_bytes(tl + idl + ml);
        end
        emit_packet({PT_PUBLISH, dup, qos, 1'($urandom_range(0, 1))},
                    big || $urandom_range(0, 3) == 0);
    endtask

    function automatic logic [3:0] ack_kind(input int sel);
        case (sel)
            0:       return PT_PUBACK;
            1:       return PT_PUBCOMP;
            2:       return PT_SUBACK;
            3:       return PT_UNSUBACK;
            default: return PT_PINGRESP;
        endcase
    endfunction

    function automatic logic [3:0] bad_kind(input int sel);
        case (sel)
            0:       return 4'h0;
            1:       return 4'h1;
            2:       return 4'h8;
            3:       return 4'hA;
            4:       return 4'hC;
            5:       return 4'hE;
            default: return 4'hF;
        endcase
    endfunction

    task automatic random_step();
        int pick;
        logic [3:0] nib;
        // Keep the session open most of the time so packets are parsed.
        if ((sess == SES_CLOSED || sess == SES_CLOSING) && $urandom_range(0, 9) != 0) begin
            push_event(MODE_OPEN);
        end
        if (sess == SES_CONNECTING && $urandom_range(0, 4) != 0) begin
            send_connack(1'b1);
        end
        pick = $urandom_range(0, 99);
        body_q.delete();
        if (pick < 35) begin
            send_publish($urandom_range(0, 199) == 0);
        end else if (pick < 45) begin
            nib = $urandom_range(0, 1) ? PT_PUBREC : PT_PUBREL;
            add_random_bytes($urandom_range(0, 4) != 0 ? 2 : $urandom_range(0, 5));
            emit_packet({nib, 4'($urandom_range(0, 15))}, $urandom_range(0, 3) == 0);
        end else if (pick < 60) begin
            add_random_bytes($urandom_range(0, 4));
            emit_packet({ack_kind($urandom_range(0, 4)), 4'($urandom_range(0, 15))},
                        $urandom_range(0, 3) == 0);
        end else if (pick < 65) begin
            send_connack(1'b0);
        end else if (pick < 70) begin
            push_byte({bad_kind($urandom_range(0, 6)), 4'($urandom_range(0, 15))});
        end else if (pick < 80) begin
            push_read(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            push_event($urandom_range(0, 1) ? MODE_OPEN : MODE_CLOSE);
        end else if (pick < 90) begin
            // Two-byte remaining length of 256 or more.
            push_byte({ack_kind($urandom_range(0, 4)), 4'($urandom_range(0, 15))});
            push_byte({1'b1, 7'($urandom_range(0, 127))});
            push_byte(8'($urandom_range(2, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        bit big_done;
        big_done    = 1'b0;
        sess        = SES_CLOSED;
        phase       = PH_TYPE;
        pkt_hdr     = '0;
        pkt_len     = '0;
        fill_pos    = '0;
        lead_id     = '0;
        foreach (pay_mem[i]) begin
            pay_mem[i]     = '0;
            pay_written[i] = 1'b0;
        end

        // Directed opening: bytes in a closed session are ignored, an unknown
        // type is a protocol error and bytes after it are dropped until the
        // next open event.
        push_byte(8'hFF);
        push_event(MODE_OPEN);
        push_byte(8'h00);
        push_byte({PT_CONNACK, 4'h0});
        push_event(MODE_OPEN);
        body_q = '{8'h00, 8'h00};
        emit_packet({PT_CONNACK, 4'h0}, 1'b0);
        // Qos 1 publish with a one-byte topic and a two-byte message.
        body_q = '{8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF, 8'h00};
        emit_packet({PT_PUBLISH, 4'b0010}, 1'b0);
        // Zero remaining length sent in the two-byte form.
        push_byte({PT_PINGRESP, 4'h0});
        push_byte(8'h80);
        push_byte(8'h00);
        body_q = '{8'hFF, 8'hFF};
        emit_packet({PT_PUBREL, 4'h2}, 1'b0);
        push_read(8'd2);
        // Remaining length far beyond the buffer.
        push_byte({PT_PUBACK, 4'h0});
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_event(MODE_CLOSE);

        while (tx_words.size() < WORD_TARGET) begin
            // One full-size publish fills buffer bytes 0 to 254 so reads can reach each of them.
            if (!big_done && tx_words.size() > 600 && sess == SES_OPEN) begin
                send_publish(1'b1);
                big_done = 1'b1;
            end
            random_step();
        end
        total_words = tx_words.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent < total_words || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Idle rates: the sender is mostly busy while the receiver stalls a lot,
    // then the two swap, and the final third runs with no idling at all.
    function automatic int send_gap_pct();
        if (words_sent < total_words / 3) return 7;
        if (words_sent < 2 * total_words / 3) return 57;
        return 0;
    endfunction

    function automatic int take_gap_pct();
        if (words_sent < total_words / 3) return 57;
        if (words_sent < 2 * total_words / 3) return 7;
        return 0;
    endfunction

    // Driver: a word stays on the bus until it is taken; a new one (or a gap)
    // is chosen only when the bus is free or the current word is accepted.
    always @(posedge aclk) begin
        in_word_t w;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
                    w = tx_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {w.addr, w.rx};
                    s_tuser  <= w.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Monitor: every accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin
        outcome_t seen, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.ev          = m_tuser;
                seen.reply_valid = m_tdata[0];
                seen.reply_type  = m_tdata[8:1];
                seen.reply_id    = m_tdata[24:9];
                seen.qos         = m_tdata[26:25];
                seen.retain      = m_tdata[27];
                seen.topic_cnt   = m_tdata[35:28];
                seen.msg_start   = m_tdata[43:36];
                seen.msg_len     = m_tdata[51:44];
                seen.read_data   = m_tdata[59:52];
                seen.session     = m_tdata[61:60];
                seen.pad         = m_tdata[63:62];
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", 16'(seen.ev), 16'(want.ev));
                    check_field("reply_valid", 16'(seen.reply_valid),
                                16'(want.reply_valid));
                    check_field("reply_type", 16'(seen.reply_type), 16'(want.reply_type));
                    check_field("reply_id", seen.reply_id, want.reply_id);
                    check_field("pub_qos", 16'(seen.qos), 16'(want.qos));
                    check_field("pub_retain", 16'(seen.retain), 16'(want.retain));
                    check_field("topic_length", 16'(seen.topic_cnt), 16'(want.topic_cnt));
                    check_field("msg_start", 16'(seen.msg_start), 16'(want.msg_start));
                    check_field("msg_length", 16'(seen.msg_len), 16'(want.msg_len));
                    check_field("read_data", 16'(seen.read_data), 16'(want.read_data));
                    check_field("session", 16'(seen.session), 16'(want.session));
                    check_field("padding", 16'(seen.pad), 16'(want.pad));
                end
                results_seen <= results_seen + 1;
            end
            m_tready <= ($urandom_range(0, 99) >= take_gap_pct());
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ===== mqtt_client_packet_receiver.f =====
rtl/mqcr_pkg.sv
rtl/mqcr_ram.sv
rtl/mqcr_parser.sv
rtl/mqtt_client_packet_receiver.sv
rtl/mqcr_checker.sv
tb/mqtt_client_packet_receiver_tb.sv
